// ===== design/ucc_pkg.sv =====
`default_nettype none
package ucc_pkg;

	localparam logic [7:0] LEAD_FIRST  = 8'hD0;
	localparam logic [7:0] LEAD_SECOND = 8'hD1;
	localparam logic [7:0] UPPER_BASE  = 8'h90;
	localparam logic [7:0] UPPER_TOP   = 8'hAF;
	localparam logic [7:0] LOWER_BASE  = 8'hB0;
	localparam logic [7:0] LOWER_TOP   = 8'hBF;
	localparam logic [7:0] PAGE2_BASE  = 8'h80;
	localparam logic [7:0] PAGE2_TOP   = 8'h8F;
	localparam logic [3:0] LOWER_HI    = 4'hB;
	localparam logic [3:0] PAGE2_HI    = 4'h8;

	localparam int QUEUE_DEPTH = 2;

	localparam logic REG_SHIFT   = 1'b0;
	localparam logic REG_DECRYPT = 1'b1;

	typedef struct packed {
		logic       letter;
		logic       upper;
		logic       two;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
	} entry_t;

endpackage
`default_nettype wire

// ===== design/utf8_cyrillic_caesar_shift_core.sv =====
`default_nettype none
// utf8 cyrillic caesar shift: takes one utf-8 byte per cycle on s_axis and rotates each of the
// 32 basic russian letters (two-byte pairs led by 0xd0/0xd1, yo excluded) within its case by
// shift_amount, or by its negation when decrypt_mode is set; all other bytes pass through and a
// lead byte left uncompleted is emitted unchanged, flushed at the latest by tlast. a front stage
// classifies input beats and holds a pending lead byte, a queue of QUEUE_DEPTH entries decouples
// it from the back stage that rotates letters and sends one output beat per cycle while
// m_tready is high. an input beat is taken every cycle while the queue has room; a held lead
// yields no output beat, plain bytes one, letters two, and a byte flushing a held lead two
// (one if held anew); the output side sets throughput; beats are registered after the queue.
// registers: shift_amount at address 0, decrypt_mode at address 4; write them only while idle.
module utf8_cyrillic_caesar_shift_core #(
	parameter int QUEUE_DEPTH = ucc_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // in_byte[7:0]
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic            reg_sel;
	logic [4:0]      shift_amount_q;
	logic            decrypt_mode_q;
	logic            cfg_wr;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	ucc_pkg::entry_t push_entry;
	ucc_pkg::entry_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_amount_q <= '0;
			decrypt_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			if (reg_sel == ucc_pkg::REG_SHIFT) begin
				shift_amount_q <= pwdata[4:0];
			end else begin
				decrypt_mode_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		case (reg_sel)
			ucc_pkg::REG_SHIFT:   prdata = {27'd0, shift_amount_q};
			ucc_pkg::REG_DECRYPT: prdata = {31'd0, decrypt_mode_q};
			default:              prdata = '0;
		endcase
	end

	ucc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_byte     (s_tdata),
		.end_of_text (s_tlast),
		.q_full      (q_full),
		.in_ready    (s_tready),
		.push        (push),
		.push_entry  (push_entry)
	);

	ucc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (head)
	);

	ucc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.shift_amount (shift_amount_q),
		.decrypt_mode (decrypt_mode_q),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.last_of_run  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== design/ucc_front.sv =====
`default_nettype none
module ucc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire  [7:0]          in_byte,
	input  wire                 end_of_text,
	input  wire                 q_full,
	output logic                in_ready,
	output logic                push,
	output ucc_pkg::entry_t     push_entry
);

	logic held_q;
	logic page_q;
	logic acc;
	logic is_lead;
	logic is_upper;
	logic is_lower;
	logic letter;
	logic [7:0] lead_byte;
	logic [7:0] up_off;

	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;
	assign lead_byte = page_q ? ucc_pkg::LEAD_SECOND : ucc_pkg::LEAD_FIRST;
	assign is_lead   = (in_byte == ucc_pkg::LEAD_FIRST) || (in_byte == ucc_pkg::LEAD_SECOND);
	assign is_upper  = !page_q && (in_byte inside {[ucc_pkg::UPPER_BASE:ucc_pkg::UPPER_TOP]});
	assign is_lower  = (!page_q && (in_byte inside {[ucc_pkg::LOWER_BASE:ucc_pkg::LOWER_TOP]}))
		|| (page_q && (in_byte inside {[ucc_pkg::PAGE2_BASE:ucc_pkg::PAGE2_TOP]}));
	assign letter    = held_q && (is_upper || is_lower);
	assign up_off    = in_byte - ucc_pkg::UPPER_BASE;

	always_comb begin
		push_entry = '0;
		push_entry.letter = letter;
		push_entry.upper  = is_upper;
		if (letter) begin
			push_entry.two    = 1'b1;
			push_entry.byte_a = is_upper ? {3'b000, up_off[4:0]} : {3'b000, page_q, in_byte[3:0]};
		end else if (held_q) begin
			push_entry.two    = !is_lead || end_of_text;
			push_entry.byte_a = lead_byte;
			push_entry.byte_b = in_byte;
		end else begin
			push_entry.two    = 1'b0;
			push_entry.byte_a = in_byte;
		end
	end

	assign push = acc && (letter || held_q || !is_lead || end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			page_q <= 1'b0;
		end else if (acc) begin
			held_q <= !letter && is_lead && !end_of_text;
			page_q <= !letter && is_lead && !end_of_text && (in_byte == ucc_pkg::LEAD_SECOND);
		end
	end

`ifndef ASSERT_OFF
	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_lead && !end_of_text && !letter |=> held_q)
		else $error("lead byte not held");
`endif

endmodule
`default_nettype wire

// ===== design/ucc_queue.sv =====
`default_nettype none
module ucc_queue #(
	parameter int DEPTH = ucc_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  ucc_pkg::entry_t     push_entry,
	input  wire                 pop,
	output logic                full,
	output logic                empty,
	output ucc_pkg::entry_t     head
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	ucc_pkg::entry_t      store_q [DEPTH];
	logic [PtrW-1:0]      wr_q;
	logic [PtrW-1:0]      rd_q;
	logic [CntW-1:0]      cnt_q;

	assign full  = (cnt_q == FullCnt);
	assign empty = (cnt_q == '0);
	assign head  = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== design/ucc_back.sv =====
`default_nettype none
module ucc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [4:0]          shift_amount,
	input  wire                 decrypt_mode,
	input  wire                 q_empty,
	input  ucc_pkg::entry_t     head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic                last_of_run
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       beat_q;
	logic       load;
	logic [4:0] k;
	logic [4:0] idx;
	logic [7:0] b0;
	logic [7:0] b1;
	logic       final_beat;

	assign k   = decrypt_mode ? 5'(5'd0 - shift_amount) : shift_amount;
	assign idx = head.byte_a[4:0] + k;

	always_comb begin
		if (head.letter) begin
			if (head.upper) begin
				b0 = ucc_pkg::LEAD_FIRST;
				b1 = ucc_pkg::UPPER_BASE + {3'b000, idx};
			end else if (!idx[4]) begin
				b0 = ucc_pkg::LEAD_FIRST;
				b1 = {ucc_pkg::LOWER_HI, idx[3:0]};
			end else begin
				b0 = ucc_pkg::LEAD_SECOND;
				b1 = {ucc_pkg::PAGE2_HI, idx[3:0]};
			end
		end else begin
			b0 = head.byte_a;
			b1 = head.byte_b;
		end
	end

	assign load       = !q_empty && (!valid_q || out_ready);
	assign final_beat = beat_q || !head.two;
	assign pop        = load && final_beat;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= beat_q ? b1 : b0;
			last_q <= final_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= !final_beat;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

`ifndef ASSERT_OFF
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q |-> (!q_empty && head.two))
		else $error("second beat without two-byte entry");
`endif

endmodule
`default_nettype wire
